@@ sv/bitmap_bit_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Bitmap bit allocator assertion macros
// Concurrent assertion shorthands clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_BIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap bit allocator package
// Field widths, codes and sequencer states shared by the allocator files.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int BIT_NUM_W = 16;
	localparam int MAP_REG_W = 17;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK,
		STAT_NOFREE,
		STAT_RDONLY,
		STAT_WASCLEAR
	} status_t;

	typedef enum logic {
		ACT_ALLOC,
		ACT_FREE
	} action_t;

	typedef enum logic {
		MAP_INODE,
		MAP_ZONE
	} map_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_READ_ONLY,
		CFG_INODE_BITS,
		CFG_ZONE_BITS
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_BASE,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

@@ sv/bba_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap bit allocator word RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/bitmap_bit_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap bit allocator
// Next-fit allocate and free over an inode bitmap and a zone bitmap, each held
// in a word RAM and scanned one word per cycle.
// ----------------------------------------------------------------------------
//  channel | handshake                    | beat
//  --------+------------------------------+------------------------------------
//  in      | in_valid / in_stall          | action, map_select, bit_number
//  out     | out_valid / out_stall        | result_bit, status
//  cfg     | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
//  After reset both RAMs are cleared, one word a cycle, with in_stall high;
//  cfg beats are taken throughout. Free: ST_MUL, ST_BASE, ST_FREE_RD,
//  ST_FREE_CHK, then ST_RESP. Allocate: ST_MUL, ST_BASE, then ST_SCAN over
//  up to NWORDS words through the single RAM read port, then ST_RESP. Read-only
//  rejections and frees at or above MAP_CAPACITY go straight to ST_RESP. One
//  item at a time; the next beat is taken while a result waits on out.
// ----------------------------------------------------------------------------
`include "bitmap_bit_allocator_assert.svh"

module bitmap_bit_allocator #(
	parameter int WORD_BITS    = 32,
	parameter int MAP_CAPACITY = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic                          map_select,
	input  logic [bba_pkg::BIT_NUM_W-1:0] bit_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::BIT_NUM_W-1:0] result_bit,
	output logic [bba_pkg::STATUS_W-1:0]  status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bba_pkg::MAP_REG_W-1:0] cfg_data
);

	import bba_pkg::*;

	localparam int NWORDS = (MAP_CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int OFS_W  = $clog2(WORD_BITS);
	localparam int CNT_W  = $clog2(NWORDS + 1);
	localparam int BIT_W  = $clog2(NWORDS * WORD_BITS);
	localparam int MB_W   = $clog2(MAP_CAPACITY + 1);
	localparam int LIM_W  = (MB_W > MAP_REG_W) ? MB_W : MAP_REG_W;
	localparam int CMP_W  = ((LIM_W > BIT_W) ? LIM_W : BIT_W) + 1;
	localparam int SH     = BIT_NUM_W + OFS_W;
	localparam int RCP_W  = SH + 1;
	localparam int PROD_W = BIT_NUM_W + RCP_W;
	localparam longint RECIP_I = ((longint'(1) << SH) + WORD_BITS - 1) / WORD_BITS;
	localparam logic [RCP_W-1:0] RECIP    = RCP_W'(RECIP_I);
	localparam logic [CMP_W-1:0] MAP_LIM  = CMP_W'(MAP_CAPACITY);
	localparam logic [AW-1:0]    LAST_W   = AW'(NWORDS - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NWORDS - 1);
	localparam logic [CNT_W-1:0] ALL_CNT  = CNT_W'(NWORDS);

	state_t                 state_q, state_d;
	logic                   read_only_q;
	logic [MAP_REG_W-1:0]   inode_bits_q, zone_bits_q;
	logic [AW-1:0]          clr_q;
	logic [CNT_W-1:0]       iss_cnt_q, chk_cnt_q;
	logic                   vld_s1;
	logic                   out_valid_q;

	logic                   act_q, sel_q;
	logic [BIT_NUM_W-1:0]   x_q;
	logic [CMP_W-1:0]       eff_q;
	logic [AW-1:0]          q_q, w_q, w_s1;
	logic [BIT_W-1:0]       base_q, base_s1;
	logic [BIT_NUM_W-1:0]   res_bit_q, out_bit_q;
	status_t                res_st_q, out_st_q;

	logic [MAP_REG_W-1:0]   sel_bits;
	logic [CMP_W-1:0]       eff_c, bit_c, cand, rem_full;
	logic [PROD_W-1:0]      prod;
	logic [WORD_BITS-1:0]   inode_rdata, zone_rdata, rd_word, ram_wdata;
	logic [OFS_W-1:0]       ffz, rem;
	logic                   ffz_any, hit, rd_en, ram_we, we_inode, we_zone, load_out;
	logic                   accept, out_free;
	logic [AW-1:0]          ram_waddr, w_nxt;
	logic [BIT_W-1:0]       base_nxt;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign sel_bits = (map_select == MAP_ZONE) ? zone_bits_q : inode_bits_q;
	assign eff_c    = (CMP_W'(sel_bits) > MAP_LIM) ? MAP_LIM : CMP_W'(sel_bits);
	assign bit_c    = CMP_W'(bit_number);

	assign prod     = PROD_W'(x_q) * PROD_W'(RECIP);
	assign rd_word  = (sel_q == MAP_ZONE) ? zone_rdata : inode_rdata;
	assign rem_full = CMP_W'(x_q) - CMP_W'(base_q);
	assign rem      = rem_full[OFS_W-1:0];

	assign w_nxt    = (w_q == LAST_W) ? '0 : w_q + 1'b1;
	assign base_nxt = (w_q == LAST_W) ? '0 : base_q + BIT_W'(WORD_BITS);

	// lowest clear bit of the word being checked
	always_comb begin
		ffz = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!rd_word[k]) begin
				ffz = OFS_W'(k);
			end
		end
	end

	assign ffz_any = ~&rd_word;
	assign cand    = CMP_W'(base_s1) + CMP_W'(ffz);
	assign hit     = vld_s1 && ffz_any && (cand < eff_q);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		rd_en     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = rd_word;
		we_inode  = 1'b0;
		we_zone   = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				we_inode  = 1'b1;
				we_zone   = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == LAST_W) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (read_only_q || (action == ACT_FREE && bit_c >= MAP_LIM)) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_BASE;
			end
			ST_BASE: begin
				state_d = (act_q == ACT_FREE) ? ST_FREE_RD : ST_SCAN;
			end
			ST_FREE_RD: begin
				state_d = ST_FREE_CHK;
			end
			ST_FREE_CHK: begin
				ram_we    = rd_word[rem];
				ram_wdata = rd_word & ~(WORD_BITS'(1) << rem);
				state_d   = ST_RESP;
			end
			ST_SCAN: begin
				rd_en = (iss_cnt_q != ALL_CNT);
				if (hit) begin
					ram_we    = 1'b1;
					ram_waddr = w_s1;
					ram_wdata = rd_word | (WORD_BITS'(1) << ffz);
					state_d   = ST_RESP;
				end else if (vld_s1 && chk_cnt_q == LAST_CNT) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (ram_we) begin
			we_inode = (sel_q == MAP_INODE);
			we_zone  = (sel_q == MAP_ZONE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_only_q  <= 1'b0;
			inode_bits_q <= MAP_REG_W'(65536);
			zone_bits_q  <= MAP_REG_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_READ_ONLY:  read_only_q  <= cfg_data[0];
				CFG_INODE_BITS: inode_bits_q <= cfg_data;
				CFG_ZONE_BITS:  zone_bits_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			iss_cnt_q   <= '0;
			chk_cnt_q   <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_BASE) begin
				iss_cnt_q <= '0;
				chk_cnt_q <= '0;
				vld_s1    <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				vld_s1 <= rd_en;
				if (rd_en) begin
					iss_cnt_q <= iss_cnt_q + 1'b1;
				end
				if (vld_s1) begin
					chk_cnt_q <= chk_cnt_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					act_q     <= action;
					sel_q     <= map_select;
					eff_q     <= eff_c;
					x_q       <= (action == ACT_ALLOC && bit_c >= eff_c) ? '0 : bit_number;
					res_bit_q <= '0;
					res_st_q  <= read_only_q ? STAT_RDONLY : STAT_WASCLEAR;
				end
			end
			ST_MUL: begin
				q_q <= AW'(prod >> SH);
			end
			ST_BASE: begin
				base_q <= BIT_W'(q_q) * BIT_W'(WORD_BITS);
				w_q    <= q_q;
			end
			ST_FREE_CHK: begin
				res_st_q <= rd_word[rem] ? STAT_OK : STAT_WASCLEAR;
			end
			ST_SCAN: begin
				if (rd_en) begin
					w_q     <= w_nxt;
					base_q  <= base_nxt;
					w_s1    <= w_q;
					base_s1 <= base_q;
				end
				if (vld_s1) begin
					res_st_q <= hit ? STAT_OK : STAT_NOFREE;
					if (hit) begin
						res_bit_q <= cand[BIT_NUM_W-1:0];
					end
				end
			end
			ST_RESP: begin
				if (load_out) begin
					out_bit_q <= res_bit_q;
					out_st_q  <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign result_bit = out_bit_q;
	assign status     = out_st_q;

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_inode_ram (
		.clk  (clk),
		.we   (we_inode),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(w_q),
		.rdata(inode_rdata)
	);

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(NWORDS)
	) u_zone_ram (
		.clk  (clk),
		.we   (we_zone),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(w_q),
		.rdata(zone_rdata)
	);

	`BBA_ASSERT_NOW(a_no_rw_clash, rd_en && ram_we, ram_waddr != w_q, "scan write hits read word")
	`BBA_ASSERT_NOW(a_chk_le_iss, state_q == ST_SCAN, chk_cnt_q <= iss_cnt_q, "checked past issued")
	`BBA_ASSERT_NEXT(a_issue_vld, state_q == ST_SCAN && rd_en, vld_s1, "issued read lost")
	`BBA_ASSERT_NOW(a_out_from_resp, $rose(out_valid_q), $past(state_q == ST_RESP), "stray result")

endmodule
